// ===== rtl/sfws_pkg.sv =====
// ---------------------------------------------------------------------------
// sfws_pkg
// Shared types, constants and the microcode table of the SPI flash write
// request splitter.
// ---------------------------------------------------------------------------
package sfws_pkg;

   localparam int unsigned DEF_MAX_REQUEST_BYTES = 4096;
   localparam int unsigned DEF_ADDRESS_BITS      = 24;

   localparam int ADDR_W  = 24;
   localparam int COUNT_W = 13;
   localparam int OPT_W   = 2;
   localparam int KIND_W  = 3;
   localparam int LEN_W   = 9;
   localparam int OFF_W   = 13;
   localparam int SIZE_W  = 25;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8388608);

   localparam int SECTOR_BITS  = 12;
   localparam int SECTOR_BYTES = 1 << SECTOR_BITS;
   localparam int PAGE_BITS    = 8;
   localparam int PAGE_BYTES   = 1 << PAGE_BITS;

   // commands before the closing item
   localparam int CMD_LIMIT       = 19;
   localparam int CMD_W           = 5;
   localparam int ERASE_RUN_LIMIT = CMD_LIMIT - 2;

   localparam int              OPT_ERASE_BIT  = 0;
   localparam int              OPT_PROG_BIT   = 1;
   localparam logic [OPT_W-1:0] OPT_NONE       = 2'b00;
   localparam logic [OPT_W-1:0] OPT_ERASE_ONLY = 2'b01;

   typedef enum logic [KIND_W-1:0] {
      KIND_ERASE   = 3'd0,
      KIND_PROGRAM = 3'd1,
      KIND_WDIS    = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_REJECT  = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MODE,
      ST_ER_SECTOR,
      ST_ER_WDIS,
      ST_PG_TEST,
      ST_PG_ETEST,
      ST_PG_ERASE,
      ST_PG_PROG,
      ST_REJECT,
      ST_DONE
   } step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_REJECT,
      COND_PROGRAM,
      COND_ER_MORE,
      COND_PG_END,
      COND_NO_ERASE,
      COND_CNT_FULL
   } cond_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_ADD_SECTOR,
      OP_ADD_LEN
   } op_type;

   typedef struct packed {
      logic     take_req;
      logic     emit;
      kind_type kind;
      logic     last;
      op_type   op;
      logic     cnt_inc;
      cond_type cond;
      step_type target;
   } cw_type;

   typedef struct packed {
      logic hold;
      logic no_req;
      logic reject;
      logic prog;
      logic er_more;
      logic pg_end;
      logic no_erase;
      logic cnt_full;
   } status_type;

   // Microcode ROM: a taken jump goes to target, otherwise the next step.
   function automatic cw_type ucode(step_type s);
      cw_type cw;
      cw = '0;
      unique case (s)
         ST_IDLE: begin
            cw.take_req = 1'b1;
            cw.cond     = COND_NO_REQ;
            cw.target   = ST_IDLE;
         end
         ST_CHECK: begin
            cw.cond   = COND_REJECT;
            cw.target = ST_REJECT;
         end
         ST_MODE: begin
            cw.cond   = COND_PROGRAM;
            cw.target = ST_PG_TEST;
         end
         ST_ER_SECTOR: begin
            cw.emit    = 1'b1;
            cw.kind    = KIND_ERASE;
            cw.op      = OP_ADD_SECTOR;
            cw.cnt_inc = 1'b1;
            cw.cond    = COND_ER_MORE;
            cw.target  = ST_ER_SECTOR;
         end
         ST_ER_WDIS: begin
            cw.emit   = 1'b1;
            cw.kind   = KIND_WDIS;
            cw.cond   = COND_ALWAYS;
            cw.target = ST_DONE;
         end
         ST_PG_TEST: begin
            cw.cond   = COND_PG_END;
            cw.target = ST_DONE;
         end
         ST_PG_ETEST: begin
            cw.cond   = COND_NO_ERASE;
            cw.target = ST_PG_PROG;
         end
         ST_PG_ERASE: begin
            cw.emit    = 1'b1;
            cw.kind    = KIND_ERASE;
            cw.cnt_inc = 1'b1;
            cw.cond    = COND_CNT_FULL;
            cw.target  = ST_DONE;
         end
         ST_PG_PROG: begin
            cw.emit    = 1'b1;
            cw.kind    = KIND_PROGRAM;
            cw.op      = OP_ADD_LEN;
            cw.cnt_inc = 1'b1;
            cw.cond    = COND_ALWAYS;
            cw.target  = ST_PG_TEST;
         end
         ST_REJECT: begin
            cw.emit   = 1'b1;
            cw.kind   = KIND_REJECT;
            cw.last   = 1'b1;
            cw.cond   = COND_ALWAYS;
            cw.target = ST_IDLE;
         end
         ST_DONE: begin
            cw.emit   = 1'b1;
            cw.kind   = KIND_DONE;
            cw.last   = 1'b1;
            cw.cond   = COND_ALWAYS;
            cw.target = ST_IDLE;
         end
         default: begin
            cw.cond   = COND_ALWAYS;
            cw.target = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/sfws_if.sv =====
// ---------------------------------------------------------------------------
// sfws_if
// Valid/ready channel interfaces: request, command and register write.
// ---------------------------------------------------------------------------
interface sfws_req_if;
   import sfws_pkg::*;

   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  start_address;
   logic [COUNT_W-1:0] byte_count;
   logic [OPT_W-1:0]   option_bits;

   modport source (output valid, start_address, byte_count, option_bits, input ready);
   modport sink   (input valid, start_address, byte_count, option_bits, output ready);
endinterface

interface sfws_rsp_if;
   import sfws_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] command_kind;
   logic [ADDR_W-1:0] flash_address;
   logic [LEN_W-1:0]  program_length;
   logic [OFF_W-1:0]  buffer_offset;
   logic              last_command;

   modport source (output valid, command_kind, flash_address, program_length,
                   buffer_offset, last_command, input ready);
   modport sink   (input valid, command_kind, flash_address, program_length,
                   buffer_offset, last_command, output ready);
endinterface

interface sfws_csr_if;
   import sfws_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/sfws_sequencer.sv =====
// ---------------------------------------------------------------------------
// sfws_sequencer
// Step counter and microcode ROM; holds the step while the datapath stalls,
// else picks the next step from the jump condition of the current control word.
// ---------------------------------------------------------------------------
module sfws_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  sfws_pkg::status_type   status,
   output sfws_pkg::cw_type       cw
);
   import sfws_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     jump;

   always_comb begin
      cw = ucode(step_ff);
   end

   always_comb begin
      unique case (cw.cond)
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = status.no_req;
         COND_REJECT:   jump = status.reject;
         COND_PROGRAM:  jump = status.prog;
         COND_ER_MORE:  jump = status.er_more;
         COND_PG_END:   jump = status.pg_end;
         COND_NO_ERASE: jump = status.no_erase;
         COND_CNT_FULL: jump = status.cnt_full;
         default:       jump = 1'b1;
      endcase
   end

   always_comb begin
      priority if (status.hold) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = cw.target;
      end else begin
         step_in = step_type'(step_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/sfws_datapath.sv =====
// ---------------------------------------------------------------------------
// sfws_datapath
// Request registers, address walker, command counter, device size register
// and the output register; all but the size register follow the control word.
// ---------------------------------------------------------------------------
module sfws_datapath #(
   parameter int unsigned MAX_REQUEST_BYTES = sfws_pkg::DEF_MAX_REQUEST_BYTES,
   parameter int unsigned ADDRESS_BITS      = sfws_pkg::DEF_ADDRESS_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sfws_pkg::cw_type     cw,
   output sfws_pkg::status_type status,
   sfws_req_if.sink             req_ch,
   sfws_rsp_if.source           rsp_ch,
   sfws_csr_if.sink             csr_ch
);
   import sfws_pkg::*;

   // two spare bits: end may pass the address space, and cur one sector past end
   localparam int CUR_W  = ADDRESS_BITS + 2;
   localparam int MAXB_W = $clog2(MAX_REQUEST_BYTES + 1);
   localparam int CMPB_W = (MAXB_W > COUNT_W) ? MAXB_W : COUNT_W;
   localparam int CMPS_W = (CUR_W > SIZE_W) ? CUR_W : SIZE_W;

   logic [ADDRESS_BITS-1:0] start_ff, start_in;
   logic [CUR_W-1:0]        end_ff, end_in;
   logic [CUR_W-1:0]        cur_ff, cur_in;
   logic [OPT_W-1:0]        opt_ff, opt_in;
   logic                    reject_ff, reject_in;
   logic [CMD_W-1:0]        count_ff, count_in;
   logic [SIZE_W-1:0]       size_ff, size_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                kind_ff, kind_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [OFF_W-1:0]        off_ff, off_in;
   logic                    last_ff, last_in;

   logic                    accept;
   logic                    hold;
   logic [ADDRESS_BITS-1:0] start_m;
   logic [CUR_W-1:0]        end_calc;
   logic [CUR_W-1:0]        start_sector;
   logic [CUR_W-1:0]        sector_next;
   logic [LEN_W-1:0]        page_len;
   logic                    is_cmd;

   assign accept = cw.take_req && req_ch.valid;
   assign hold   = cw.emit && rsp_valid_ff && !rsp_ch.ready;

   assign req_ch.ready = cw.take_req;
   assign csr_ch.ready = 1'b1;

   assign start_m      = req_ch.start_address[ADDRESS_BITS-1:0];
   assign end_calc     = CUR_W'(start_m) + CUR_W'(req_ch.byte_count);
   assign start_sector = CUR_W'({start_m[ADDRESS_BITS-1:SECTOR_BITS], SECTOR_BITS'(0)});
   assign sector_next  = cur_ff + CUR_W'(SECTOR_BYTES);

   // last page runs to end, others to the page boundary
   always_comb begin
      if (end_ff[CUR_W-1:PAGE_BITS] == cur_ff[CUR_W-1:PAGE_BITS]) begin
         page_len = LEN_W'(end_ff - cur_ff);
      end else begin
         page_len = LEN_W'(PAGE_BYTES) - LEN_W'(cur_ff[PAGE_BITS-1:0]);
      end
   end

   always_comb begin
      status.hold     = hold;
      status.no_req   = !req_ch.valid;
      status.reject   = reject_ff;
      status.prog     = opt_ff[OPT_PROG_BIT];
      status.er_more  = (sector_next <= end_ff) && (count_ff < CMD_W'(ERASE_RUN_LIMIT));
      status.pg_end   = !((cur_ff < end_ff) && (count_ff < CMD_W'(CMD_LIMIT)));
      status.no_erase = !(opt_ff[OPT_ERASE_BIT] && (cur_ff[SECTOR_BITS-1:0] == '0));
      status.cnt_full = count_ff >= CMD_W'(CMD_LIMIT - 1);
   end

   always_comb begin
      start_in  = start_ff;
      end_in    = end_ff;
      opt_in    = opt_ff;
      reject_in = reject_ff;
      cur_in    = cur_ff;
      count_in  = count_ff;
      if (accept) begin
         start_in  = start_m;
         end_in    = end_calc;
         opt_in    = req_ch.option_bits;
         reject_in = (req_ch.option_bits == OPT_NONE)
                  || (CMPB_W'(req_ch.byte_count) > CMPB_W'(MAX_REQUEST_BYTES))
                  || (CMPS_W'(end_calc) >= CMPS_W'(size_ff));
         cur_in    = (req_ch.option_bits == OPT_ERASE_ONLY) ? start_sector
                                                            : CUR_W'(start_m);
         count_in  = '0;
      end else if (!hold) begin
         unique case (cw.op)
            OP_HOLD:       cur_in = cur_ff;
            OP_ADD_SECTOR: cur_in = sector_next;
            OP_ADD_LEN:    cur_in = cur_ff + CUR_W'(page_len);
            default:       cur_in = cur_ff;
         endcase
         if (cw.cnt_inc) begin
            count_in = count_ff + CMD_W'(1);
         end
      end
   end

   always_comb begin
      size_in = csr_ch.valid ? csr_ch.data : size_ff;
   end

   // output register: a beat waits here while the sequencer moves on
   always_comb begin
      is_cmd       = (cw.kind == KIND_ERASE) || (cw.kind == KIND_PROGRAM);
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      last_in      = last_ff;
      if (cw.emit && !hold) begin
         rsp_valid_in = 1'b1;
         kind_in      = cw.kind;
         addr_in      = is_cmd ? ADDR_W'(cur_ff[ADDRESS_BITS-1:0]) : '0;
         len_in       = (cw.kind == KIND_PROGRAM) ? page_len : '0;
         off_in       = (cw.kind == KIND_PROGRAM) ? OFF_W'(cur_ff - CUR_W'(start_ff)) : '0;
         last_in      = cw.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      end_ff    <= end_in;
      cur_ff    <= cur_in;
      opt_ff    <= opt_in;
      reject_ff <= reject_in;
      kind_ff   <= kind_in;
      addr_ff   <= addr_in;
      len_ff    <= len_in;
      off_ff    <= off_in;
      last_ff   <= last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.command_kind   = kind_ff;
   assign rsp_ch.flash_address  = addr_ff;
   assign rsp_ch.program_length = len_ff;
   assign rsp_ch.buffer_offset  = off_ff;
   assign rsp_ch.last_command   = last_ff;

endmodule

// ===== rtl/spi_flash_write_request_splitter_top.sv =====
// ---------------------------------------------------------------------------
// spi_flash_write_request_splitter_top
// Turns one flash write request into its list of erase/program commands.
//
// req_ch takes a request (start address, byte count, option bits) in the
// idle step only; one request is worked on at a time. rsp_ch gives one
// command per beat, the run closed by a done or rejected beat with
// last_command set. csr_ch writes the device size and is always ready.
// A rejected request goes from the idle step through the check step to the
// reject step, whose beat closes the run, and the sequencer then returns to
// idle for the next request. Otherwise erase-only mode loops in one step
// that emits the sector erases, then gives a write-disable beat; program mode
// walks the test, erase-test and program steps per page, with an erase step
// before a page that opens a sector when the erase option is set.
// A beat waits in the output register; when the receiver stalls, the step
// that emits the next beat holds until the register frees.
// Reset returns the sequencer to idle, drops rsp valid and sets the device
// size to 8 MiB.
// ---------------------------------------------------------------------------
module spi_flash_write_request_splitter_top #(
   parameter int unsigned MAX_REQUEST_BYTES = sfws_pkg::DEF_MAX_REQUEST_BYTES,
   parameter int unsigned ADDRESS_BITS      = sfws_pkg::DEF_ADDRESS_BITS
) (
   input  logic       clock,
   input  logic       reset,
   sfws_req_if.sink   req_ch,
   sfws_rsp_if.source rsp_ch,
   sfws_csr_if.sink   csr_ch
);
   import sfws_pkg::*;

   cw_type     cw;
   status_type status;

   sfws_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   sfws_datapath #(
      .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
      .ADDRESS_BITS      (ADDRESS_BITS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cw     (cw),
      .status (status),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

endmodule

// ===== rtl/sfws_checker.sv =====
// ---------------------------------------------------------------------------
// sfws_checker
// Port-level checks on the command channel of the splitter.
// ---------------------------------------------------------------------------
module sfws_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sfws_pkg::KIND_W-1:0] rsp_kind,
   input logic [sfws_pkg::ADDR_W-1:0] rsp_addr,
   input logic [sfws_pkg::LEN_W-1:0]  rsp_len,
   input logic [sfws_pkg::OFF_W-1:0]  rsp_off,
   input logic                        rsp_last
);
   import sfws_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("command valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_addr)
                                  && $stable(rsp_len) && $stable(rsp_last))
      else $error("stalled command beat changed");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == ((rsp_kind == KIND_DONE) || (rsp_kind == KIND_REJECT))))
      else $error("last flag not on the closing beat");

   a_len_only_prog: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_PROGRAM) |-> (rsp_len == '0) && (rsp_off == '0))
      else $error("length or offset on a non-program beat");

   a_prog_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_PROGRAM) |-> (rsp_len != '0)
                                              && (rsp_len <= LEN_W'(PAGE_BYTES)))
      else $error("page program length out of range");

endmodule

bind spi_flash_write_request_splitter_top sfws_checker u_sfws_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.command_kind),
   .rsp_addr  (rsp_ch.flash_address),
   .rsp_len   (rsp_ch.program_length),
   .rsp_off   (rsp_ch.buffer_offset),
   .rsp_last  (rsp_ch.last_command)
);
